// ===== hw/rtl/ffha_pkg.sv =====
// ffha_pkg: shared types and constants of the first-fit heap allocator
// header layout, status codes, controller states, commands and status flags
// no dependencies
package ffha_pkg;

  localparam int HEAP_WORDS   = 4096;
  localparam int ADDR_W       = 12;
  localparam int HEADER_WORDS = 4;
  localparam int WORD_SHIFT   = 3;
  localparam int WORD_BYTES   = 8;
  localparam int FIELD_W      = 16;
  localparam int WIDE_W       = 17;
  localparam int WORDS_W      = 14;

  typedef struct packed {
    logic               occ;
    logic               last;
    logic [FIELD_W-1:0] size;
    logic [FIELD_W-1:0] back;
  } hdr_t;

  typedef enum logic [1:0] {
    STS_ALLOC  = 2'd0,
    STS_NOFIT  = 2'd1,
    STS_FREED  = 2'd2
  } sts_code_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_A_RD, ST_A_CHK, ST_A_WS, ST_F_RD, ST_F_H, ST_F_N,
    ST_F_WH, ST_F_P, ST_F_WP, ST_B_CHK, ST_B_ISS, ST_B_RD, ST_RESP
  } state_t;

  typedef enum logic [3:0] {
    C_NONE, C_CLEAR, C_LOAD, C_RD_CUR, C_A_CHK, C_A_WS, C_F_H, C_F_N, C_F_WH,
    C_F_P, C_F_WP, C_B_CHK, C_B_ISS, C_B_RD
  } cmd_t;

  typedef struct packed {
    logic op_free;
    logic p_low;
    logic clr_last;
    logic fit;
    logic whole;
    logic rd_last;
    logic rd_next_ok;
    logic has_prev;
    logic b_need;
  } dp_sts_t;

endpackage

// ===== hw/rtl/first_fit_heap_allocator_core.sv =====
// first_fit_heap_allocator_core: top level of the first-fit heap allocator
// joins ffha_ctrl and ffha_dp; depends on ffha_pkg
//
// input channel: in_valid/in_ready with opcode, request_bytes, payload_offset
// output channel: out_valid/out_ready with status, granted_offset
// one result beat per input beat, one item in flight at a time
// after rst the header memory is cleared, one entry a cycle,
// with entry 0 set to one free last block; in_ready is low meanwhile
// allocate: a header read and a fit check per header visited, then the split
// header write and the back-size update of the following block where needed
// free: header, next merge, previous merge, back-size update;
// an offset below one header goes straight to the result
// each step is set by the single read port of the header memory
// the result is held in registers until out_ready; while the receiver
// stalls no new item is taken
module first_fit_heap_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [15:0] request_bytes,
  input  logic [11:0] payload_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [11:0] granted_offset
);

  ffha_pkg::cmd_t    cmd;
  ffha_pkg::dp_sts_t sts;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffha_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .opcode         (opcode),
    .request_bytes  (request_bytes),
    .payload_offset (payload_offset),
    .sts            (sts),
    .status         (status),
    .granted_offset (granted_offset)
  );

endmodule

// ===== hw/rtl/ffha_dp.sv =====
// ffha_dp: header memory, walk registers and header arithmetic
// acts on commands from ffha_ctrl; depends on ffha_pkg
module ffha_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  ffha_pkg::cmd_t         cmd,
  input  logic                   opcode,
  input  logic [15:0]            request_bytes,
  input  logic [11:0]            payload_offset,
  output ffha_pkg::dp_sts_t      sts,
  output logic [1:0]             status,
  output logic [11:0]            granted_offset
);

  ffha_pkg::hdr_t mem [ffha_pkg::HEAP_WORDS];
  ffha_pkg::hdr_t rdata;
  ffha_pkg::hdr_t hdr;
  ffha_pkg::hdr_t wdata;
  logic [ffha_pkg::ADDR_W-1:0]  raddr;
  logic [ffha_pkg::ADDR_W-1:0]  waddr;
  logic                         we;
  logic [ffha_pkg::ADDR_W-1:0]  cur;
  logic [ffha_pkg::ADDR_W-1:0]  baddr;
  logic [ffha_pkg::ADDR_W-1:0]  clr;
  logic [ffha_pkg::FIELD_W-1:0] bval;
  logic [ffha_pkg::WORDS_W-1:0] words;
  logic [1:0]                   res_sts;
  logic [ffha_pkg::ADDR_W-1:0]  res_off;

  logic [ffha_pkg::WIDE_W-1:0]  a_next;
  logic [ffha_pkg::WIDE_W-1:0]  split;
  logic [ffha_pkg::WIDE_W-1:0]  bn;
  logic [ffha_pkg::WIDE_W-1:0]  back_lim;
  logic [ffha_pkg::WIDE_W-1:0]  req_sum;
  logic [ffha_pkg::FIELD_W-1:0] rem;
  logic [ffha_pkg::ADDR_W-1:0]  pv;
  ffha_pkg::hdr_t               init_hdr;

  localparam logic [ffha_pkg::WIDE_W-1:0] HW  = ffha_pkg::WIDE_W'(ffha_pkg::HEADER_WORDS);
  localparam logic [ffha_pkg::WIDE_W-1:0] TOP = ffha_pkg::WIDE_W'(ffha_pkg::HEAP_WORDS);

  always_comb begin
    a_next   = ffha_pkg::WIDE_W'(cur) + HW + ffha_pkg::WIDE_W'(rdata.size);
    split    = ffha_pkg::WIDE_W'(cur) + HW + ffha_pkg::WIDE_W'(words);
    bn       = ffha_pkg::WIDE_W'(cur) + HW + ffha_pkg::WIDE_W'(hdr.size);
    back_lim = ffha_pkg::WIDE_W'(hdr.back) + HW;
    req_sum  = ffha_pkg::WIDE_W'(request_bytes) + ffha_pkg::WIDE_W'(ffha_pkg::WORD_BYTES - 1);
    rem      = rdata.size - ffha_pkg::FIELD_W'(words);
    pv       = cur - hdr.back[ffha_pkg::ADDR_W-1:0]
               - ffha_pkg::ADDR_W'(ffha_pkg::HEADER_WORDS);
    init_hdr.occ  = 1'b0;
    init_hdr.last = 1'b1;
    init_hdr.size = ffha_pkg::FIELD_W'(ffha_pkg::HEAP_WORDS - ffha_pkg::HEADER_WORDS);
    init_hdr.back = '0;

    sts.op_free    = opcode;
    sts.p_low      = payload_offset < ffha_pkg::ADDR_W'(ffha_pkg::HEADER_WORDS);
    sts.clr_last   = &clr;
    sts.fit        = !rdata.occ && (rdata.size >= ffha_pkg::FIELD_W'(words));
    sts.whole      = (rem <= ffha_pkg::FIELD_W'(ffha_pkg::HEADER_WORDS)) || (split >= TOP);
    sts.rd_last    = rdata.last;
    sts.rd_next_ok = a_next < TOP;
    sts.has_prev   = (hdr.back != '0) && (ffha_pkg::WIDE_W'(cur) >= back_lim);
    sts.b_need     = !hdr.last && (bn < TOP);
  end

  always_comb begin
    raddr = cur;
    we    = 1'b0;
    waddr = cur;
    wdata = hdr;
    case (cmd)
      ffha_pkg::C_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
        wdata = (clr == '0) ? init_hdr : '0;
      end
      ffha_pkg::C_A_CHK: begin
        if (sts.fit) begin
          we = 1'b1;
          wdata = rdata;
          wdata.occ = 1'b1;
          if (!sts.whole) begin
            wdata.last = 1'b0;
            wdata.size = ffha_pkg::FIELD_W'(words);
          end
        end
      end
      ffha_pkg::C_F_H:  raddr = a_next[ffha_pkg::ADDR_W-1:0];
      ffha_pkg::C_A_WS, ffha_pkg::C_F_WP: we = 1'b1;
      ffha_pkg::C_F_WH: begin
        we    = 1'b1;
        raddr = pv;
      end
      ffha_pkg::C_B_ISS: raddr = baddr;
      ffha_pkg::C_B_RD: begin
        we = 1'b1;
        waddr = baddr;
        wdata = rdata;
        wdata.back = bval;
      end
      default: raddr = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd == ffha_pkg::C_CLEAR) begin
      clr <= clr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      ffha_pkg::C_LOAD: begin
        words   <= req_sum[ffha_pkg::WORD_SHIFT +: ffha_pkg::WORDS_W];
        cur     <= opcode ? payload_offset - ffha_pkg::ADDR_W'(ffha_pkg::HEADER_WORDS) : '0;
        res_sts <= opcode ? ffha_pkg::STS_FREED : ffha_pkg::STS_NOFIT;
        res_off <= '0;
      end
      ffha_pkg::C_A_CHK: begin
        if (sts.fit) begin
          res_sts <= ffha_pkg::STS_ALLOC;
          res_off <= cur + ffha_pkg::ADDR_W'(ffha_pkg::HEADER_WORDS);
          if (sts.whole) begin
            baddr <= a_next[ffha_pkg::ADDR_W-1:0];
            bval  <= '0;
          end else begin
            hdr.occ  <= 1'b0;
            hdr.last <= rdata.last;
            hdr.size <= rem - ffha_pkg::FIELD_W'(ffha_pkg::HEADER_WORDS);
            hdr.back <= '0;
            cur      <= split[ffha_pkg::ADDR_W-1:0];
          end
        end else begin
          cur <= a_next[ffha_pkg::ADDR_W-1:0];
        end
      end
      ffha_pkg::C_F_H: begin
        hdr.occ  <= 1'b0;
        hdr.last <= rdata.last;
        hdr.size <= rdata.size;
        hdr.back <= rdata.back;
      end
      ffha_pkg::C_F_N: begin
        if (!rdata.occ) begin
          hdr.size <= hdr.size + rdata.size + ffha_pkg::FIELD_W'(ffha_pkg::HEADER_WORDS);
          hdr.last <= rdata.last;
        end
      end
      ffha_pkg::C_F_WH: begin
        if (sts.has_prev) cur <= pv;
      end
      ffha_pkg::C_F_P: begin
        hdr.occ  <= rdata.occ;
        hdr.back <= rdata.back;
        hdr.size <= rdata.size + hdr.size + ffha_pkg::FIELD_W'(ffha_pkg::HEADER_WORDS);
      end
      ffha_pkg::C_B_CHK: begin
        baddr <= bn[ffha_pkg::ADDR_W-1:0];
        bval  <= hdr.size;
      end
      default: begin
      end
    endcase
  end

  assign status         = res_sts;
  assign granted_offset = res_off;

endmodule

// ===== hw/rtl/ffha_ctrl.sv =====
// ffha_ctrl: sequencer of the allocator, clearing pass, walk and free steps
// drives ffha_dp through commands; depends on ffha_pkg
module ffha_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ffha_pkg::dp_sts_t   sts,
  output ffha_pkg::cmd_t      cmd
);

  ffha_pkg::state_t state;
  ffha_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffha_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ffha_pkg::ST_CLEAR: if (sts.clr_last) state_next = ffha_pkg::ST_IDLE;
      ffha_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (sts.op_free) state_next = sts.p_low ? ffha_pkg::ST_RESP : ffha_pkg::ST_F_RD;
          else state_next = ffha_pkg::ST_A_RD;
        end
      end
      ffha_pkg::ST_A_RD: state_next = ffha_pkg::ST_A_CHK;
      ffha_pkg::ST_A_CHK: begin
        if (sts.fit) begin
          if (!sts.whole) state_next = ffha_pkg::ST_A_WS;
          else if (!sts.rd_last && sts.rd_next_ok) state_next = ffha_pkg::ST_B_ISS;
          else state_next = ffha_pkg::ST_RESP;
        end else if (sts.rd_last || !sts.rd_next_ok) begin
          state_next = ffha_pkg::ST_RESP;
        end else begin
          state_next = ffha_pkg::ST_A_RD;
        end
      end
      ffha_pkg::ST_A_WS: state_next = ffha_pkg::ST_B_CHK;
      ffha_pkg::ST_F_RD: state_next = ffha_pkg::ST_F_H;
      ffha_pkg::ST_F_H: begin
        state_next = (!sts.rd_last && sts.rd_next_ok) ? ffha_pkg::ST_F_N : ffha_pkg::ST_F_WH;
      end
      ffha_pkg::ST_F_N:  state_next = ffha_pkg::ST_F_WH;
      ffha_pkg::ST_F_WH: state_next = sts.has_prev ? ffha_pkg::ST_F_P : ffha_pkg::ST_B_CHK;
      ffha_pkg::ST_F_P:  state_next = ffha_pkg::ST_F_WP;
      ffha_pkg::ST_F_WP: state_next = ffha_pkg::ST_B_CHK;
      ffha_pkg::ST_B_CHK: state_next = sts.b_need ? ffha_pkg::ST_B_ISS : ffha_pkg::ST_RESP;
      ffha_pkg::ST_B_ISS: state_next = ffha_pkg::ST_B_RD;
      ffha_pkg::ST_B_RD:  state_next = ffha_pkg::ST_RESP;
      ffha_pkg::ST_RESP:  if (out_ready) state_next = ffha_pkg::ST_IDLE;
      default: state_next = ffha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = ffha_pkg::C_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      ffha_pkg::ST_CLEAR: cmd = ffha_pkg::C_CLEAR;
      ffha_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = ffha_pkg::C_LOAD;
      end
      ffha_pkg::ST_A_RD, ffha_pkg::ST_F_RD: cmd = ffha_pkg::C_RD_CUR;
      ffha_pkg::ST_A_CHK: cmd = ffha_pkg::C_A_CHK;
      ffha_pkg::ST_A_WS:  cmd = ffha_pkg::C_A_WS;
      ffha_pkg::ST_F_H:   cmd = ffha_pkg::C_F_H;
      ffha_pkg::ST_F_N:   cmd = ffha_pkg::C_F_N;
      ffha_pkg::ST_F_WH:  cmd = ffha_pkg::C_F_WH;
      ffha_pkg::ST_F_P:   cmd = ffha_pkg::C_F_P;
      ffha_pkg::ST_F_WP:  cmd = ffha_pkg::C_F_WP;
      ffha_pkg::ST_B_CHK: cmd = ffha_pkg::C_B_CHK;
      ffha_pkg::ST_B_ISS: cmd = ffha_pkg::C_B_ISS;
      ffha_pkg::ST_B_RD:  cmd = ffha_pkg::C_B_RD;
      ffha_pkg::ST_RESP:  out_valid = 1'b1;
      default: cmd = ffha_pkg::C_NONE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ffha_pkg::ST_CLEAR) |-> (!in_ready && !out_valid))
    else $error("handshake during clearing pass");
  a_resp_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> (in_ready && !out_valid))
    else $error("no return to idle after result beat");
`endif

endmodule
